// ===== hdl/bmp565_pkg.sv =====
// Shared types and constants for the BMP to RGB565 pixel streamer.
package bmp565_pkg;

  localparam logic [15:0] SIG_BM     = 16'h424D;
  localparam logic [7:0]  HDR_LEN_24 = 8'h36;
  localparam logic [7:0]  HDR_LEN_16 = 8'h8A;

  localparam logic [1:0] KIND_WINDOW = 2'd0;
  localparam logic [1:0] KIND_PIXEL  = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_SIGNATURE  = 2'd1;
  localparam logic [1:0] ERR_COMPRESSED = 2'd2;
  localparam logic [1:0] ERR_SIZE       = 2'd3;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_PIXELS = 2'd1,
    PH_STOP   = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] pixel;
    logic [11:0] width_m1;
    logic [11:0] height_m1;
    logic [1:0]  error_code;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic     valid;
    in_item_t item;
  } stage_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } result_t;

endpackage

// ===== hdl/bmp565_in_stage.sv =====
// Input register stage holding one accepted file byte.
module bmp565_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  bmp565_pkg::in_item_t in_data,
  input  logic                advance_ok,
  output logic                in_ready,
  output bmp565_pkg::stage_t  stage
);
  import bmp565_pkg::*;

  logic     valid_r;
  in_item_t item_r;

  assign in_ready    = !valid_r || advance_ok;
  assign stage.valid = valid_r;
  assign stage.item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
  end

endmodule

// ===== hdl/bmp565_parser.sv =====
// Header parser and pixel packer with its state registers.
module bmp565_parser #(
  parameter int MAX_DIM = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bmp565_pkg::stage_t  stage,
  input  logic                advance_ok,
  input  logic                pixel_mode,
  output bmp565_pkg::result_t result
);
  import bmp565_pkg::*;

  localparam int          DIM_W   = $clog2(MAX_DIM + 1);
  localparam logic [31:0] MAX_W32 = 32'(MAX_DIM);

  phase_t           phase_r, phase_nxt, phase_cur;
  logic [7:0]       hdr_cnt_r, hdr_cnt_nxt, hdr_cnt_cur;
  logic [15:0]      sig_r, sig_nxt, sig_cur;
  logic [31:0]      width_r, width_nxt, width_cur;
  logic [31:0]      height_r, height_nxt, height_cur;
  logic             comp_r, comp_nxt, comp_cur;
  logic [1:0]       bip_r, bip_nxt, bip_cur;
  logic [15:0]      part_r, part_nxt, part_cur;
  logic [DIM_W-1:0] col_r, col_nxt, col_cur;
  logic [DIM_W-1:0] row_r, row_nxt, row_cur;
  logic [1:0]       pad_r, pad_nxt, pad_cur;

  logic             take;
  logic [7:0]       b;
  logic [7:0]       hdr_len;
  logic [1:0]       lane;
  logic [DIM_W-1:0] col_p1;
  logic [DIM_W-1:0] row_p1;
  logic [15:0]      pix;

  assign take    = stage.valid && advance_ok;
  assign b       = stage.item.data_byte;
  assign hdr_len = pixel_mode ? HDR_LEN_16 : HDR_LEN_24;
  assign lane    = hdr_cnt_cur[1:0] + 2'd2;

  always_comb begin
    if (stage.item.first) begin
      phase_cur   = PH_HEADER;
      hdr_cnt_cur = '0;
      sig_cur     = '0;
      width_cur   = '0;
      height_cur  = '0;
      comp_cur    = 1'b0;
      bip_cur     = '0;
      part_cur    = '0;
      col_cur     = '0;
      row_cur     = '0;
      pad_cur     = '0;
    end else begin
      phase_cur   = phase_r;
      hdr_cnt_cur = hdr_cnt_r;
      sig_cur     = sig_r;
      width_cur   = width_r;
      height_cur  = height_r;
      comp_cur    = comp_r;
      bip_cur     = bip_r;
      part_cur    = part_r;
      col_cur     = col_r;
      row_cur     = row_r;
      pad_cur     = pad_r;
    end
  end

  always_comb begin
    phase_nxt   = phase_cur;
    hdr_cnt_nxt = hdr_cnt_cur;
    sig_nxt     = sig_cur;
    width_nxt   = width_cur;
    height_nxt  = height_cur;
    comp_nxt    = comp_cur;
    bip_nxt     = bip_cur;
    part_nxt    = part_cur;
    col_nxt     = col_cur;
    row_nxt     = row_cur;
    pad_nxt     = pad_cur;
    col_p1      = col_cur + 1'b1;
    row_p1      = row_cur + 1'b1;
    pix         = '0;
    result      = '0;
    case (phase_cur)
      PH_HEADER: begin
        if (hdr_cnt_cur == 8'd0) begin
          sig_nxt = {b, 8'h00};
        end else if (hdr_cnt_cur == 8'd1) begin
          sig_nxt = {sig_cur[15:8], b};
        end else if (hdr_cnt_cur inside {[8'd18:8'd21]}) begin
          width_nxt[{lane, 3'b000} +: 8] = b;
        end else if (hdr_cnt_cur inside {[8'd22:8'd25]}) begin
          height_nxt[{lane, 3'b000} +: 8] = b;
        end else if ((hdr_cnt_cur inside {[8'd30:8'd33]}) && (b != 8'd0)) begin
          comp_nxt = 1'b1;
        end
        hdr_cnt_nxt = hdr_cnt_cur + 8'd1;
        if (hdr_cnt_nxt >= hdr_len) begin
          result.valid = 1'b1;
          if (sig_nxt != SIG_BM) begin
            phase_nxt              = PH_STOP;
            result.item.kind       = KIND_ERROR;
            result.item.error_code = ERR_SIGNATURE;
          end else if (!pixel_mode && comp_nxt) begin
            phase_nxt              = PH_STOP;
            result.item.kind       = KIND_ERROR;
            result.item.error_code = ERR_COMPRESSED;
          end else if (width_nxt == 32'd0 || width_nxt > MAX_W32 ||
                       height_nxt == 32'd0 || height_nxt > MAX_W32) begin
            phase_nxt              = PH_STOP;
            result.item.kind       = KIND_ERROR;
            result.item.error_code = ERR_SIZE;
          end else begin
            phase_nxt             = PH_PIXELS;
            bip_nxt               = '0;
            part_nxt              = '0;
            col_nxt               = '0;
            row_nxt               = '0;
            pad_nxt               = '0;
            result.item.kind      = KIND_WINDOW;
            result.item.width_m1  = 12'(width_nxt - 32'd1);
            result.item.height_m1 = 12'(height_nxt - 32'd1);
          end
        end
      end
      PH_PIXELS: begin
        if (pad_cur != 2'd0) begin
          pad_nxt = pad_cur - 2'd1;
        end else if (bip_cur == 2'd0) begin
          part_nxt = {8'h00, b};
          bip_nxt  = 2'd1;
        end else if (!pixel_mode && bip_cur == 2'd1) begin
          part_nxt = {b, part_cur[7:0]};
          bip_nxt  = 2'd2;
        end else begin
          if (!pixel_mode) begin
            pix = {b[7:3], part_cur[15:10], part_cur[7:3]};
          end else begin
            pix = {b, part_cur[7:0]};
          end
          bip_nxt           = '0;
          part_nxt          = '0;
          result.valid      = 1'b1;
          result.item.kind  = KIND_PIXEL;
          result.item.pixel = pix;
          col_nxt           = col_p1;
          if (col_p1 >= width_cur[DIM_W-1:0]) begin
            col_nxt = '0;
            row_nxt = row_p1;
            if (row_p1 >= height_cur[DIM_W-1:0]) begin
              result.item.last = 1'b1;
              phase_nxt        = PH_STOP;
            end else if (!pixel_mode) begin
              pad_nxt = width_cur[1:0];
            end else begin
              pad_nxt = {width_cur[0], 1'b0};
            end
          end
        end
      end
      default: begin
      end
    endcase
    if (!take) begin
      result.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      hdr_cnt_r <= '0;
      sig_r     <= '0;
      width_r   <= '0;
      height_r  <= '0;
      comp_r    <= 1'b0;
      bip_r     <= '0;
      part_r    <= '0;
      col_r     <= '0;
      row_r     <= '0;
      pad_r     <= '0;
    end else if (take) begin
      phase_r   <= phase_nxt;
      hdr_cnt_r <= hdr_cnt_nxt;
      sig_r     <= sig_nxt;
      width_r   <= width_nxt;
      height_r  <= height_nxt;
      comp_r    <= comp_nxt;
      bip_r     <= bip_nxt;
      part_r    <= part_nxt;
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      pad_r     <= pad_nxt;
    end
  end

endmodule

// ===== hdl/bmp565_out_stage.sv =====
// Result register stage driving the output channel.
module bmp565_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bmp565_pkg::result_t  result,
  input  logic                 out_ready,
  output logic                 advance_ok,
  output logic                 out_valid,
  output bmp565_pkg::out_item_t out_data
);
  import bmp565_pkg::*;

  logic      valid_r;
  out_item_t data_r;

  assign advance_ok = !valid_r || out_ready;
  assign out_valid  = valid_r;
  assign out_data   = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance_ok) begin
      valid_r <= result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance_ok && result.valid) begin
      data_r <= result.item;
    end
  end

endmodule

// ===== hdl/bmp_to_rgb565_pixel_streamer_core.sv =====
// Top level of the BMP to RGB565 pixel streamer.
//
// The input channel carries one file byte per transfer, with first marking
// the first byte of a new file. The parser keeps the header, checks it and
// emits one window result or one error result on the last header byte, then
// one pixel result per complete pixel, with last on the final pixel. Padding
// bytes and bytes after an error or after the final pixel give no result.
// The cfg port writes pixel_mode: 0 for a 24-bit source, 1 for 16-bit.
// One byte is taken every cycle while the output is not stalled. A transfer
// that causes a result shows it on the output once the byte moves from the
// input register into the result register; that move waits while the result
// register holds a stalled result.
// Synchronous reset empties both registers, sets pixel_mode to 24-bit and
// returns the parser to the start of a header.
// When the receiver stalls, the result waits in the result register and one
// more byte is accepted into the input register; the input then stalls too.
module bmp_to_rgb565_pixel_streamer_core #(
  parameter int MAX_DIM = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  bmp565_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output bmp565_pkg::out_item_t out_data,
  input  logic                  cfg_we,
  input  logic                  cfg_wdata
);
  import bmp565_pkg::*;

  logic    pixel_mode_r;
  logic    advance_ok;
  stage_t  stage;
  result_t result;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_mode_r <= 1'b0;
    end else if (cfg_we) begin
      pixel_mode_r <= cfg_wdata;
    end
  end

  bmp565_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .advance_ok (advance_ok),
    .in_ready   (in_ready),
    .stage      (stage)
  );

  bmp565_parser #(
    .MAX_DIM (MAX_DIM)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .stage      (stage),
    .advance_ok (advance_ok),
    .pixel_mode (pixel_mode_r),
    .result     (result)
  );

  bmp565_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .result     (result),
    .out_ready  (out_ready),
    .advance_ok (advance_ok),
    .out_valid  (out_valid),
    .out_data   (out_data)
  );

endmodule

// ===== hdl/bmp565_checker.sv =====
// Port-level checker for the pixel streamer and its bind statement.
module bmp565_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_ready,
  input bmp565_pkg::out_item_t out_data
);
  import bmp565_pkg::*;

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result channel is not empty after reset.");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Stalled result changed.");

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.kind == KIND_WINDOW || out_data.kind == KIND_PIXEL ||
                   out_data.kind == KIND_ERROR))
    else $error("Unknown result kind.");

  a_pixel_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_PIXEL |->
      out_data.error_code == ERR_NONE && out_data.width_m1 == 12'd0 &&
      out_data.height_m1 == 12'd0)
    else $error("Pixel result carries window or error fields.");

  a_error_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_ERROR |->
      out_data.error_code != ERR_NONE && out_data.pixel == 16'd0 && !out_data.last)
    else $error("Error result is malformed.");

endmodule

bind bmp_to_rgb565_pixel_streamer_core bmp565_checker u_bmp565_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
